// File: sv/wtsp_pkg.sv
// shared types, constants and helpers for the world-to-screen projection
`default_nettype none
package wtsp_pkg;
    localparam int COEF_FRAC_BITS  = 24;
    localparam int COORD_FRAC_BITS = 16;
    localparam int COEF_SHIFT      = COEF_FRAC_BITS - COORD_FRAC_BITS;

    localparam int DATA_W  = 32;
    localparam int DIM_W   = 14;
    localparam int WMIN_W  = 31;
    localparam int IDX_W   = 4;
    localparam int NUM_COEFS = 12;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int TERM_W  = PROD_W - COEF_FRAC_BITS;
    localparam int CLIP_W  = TERM_W + 2;
    localparam int MID_W   = DIM_W + COORD_FRAC_BITS - 1;
    localparam int LO_W    = 32;
    localparam int HI_W    = CLIP_W - LO_W;
    localparam int NUM_W   = MID_W + CLIP_W + 1;
    localparam int Q_W     = 33;
    localparam int TOP_W   = NUM_W - Q_W;
    localparam int MAG_W   = Q_W + 1;
    localparam int SUM_W   = MAG_W + 2;
    localparam int ADDR_W  = 4;

    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_W_MINIMUM     = 2'd2;

    localparam logic CMD_LOAD      = 1'b0;
    localparam logic CMD_TRANSFORM = 1'b1;

    localparam logic [DIM_W-1:0]  WIDTH_RESET  = DIM_W'(1920);
    localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(1080);
    localparam logic [WMIN_W-1:0] WMIN_RESET   = WMIN_W'(42598);

    typedef struct packed {
        logic                     command;
        logic [IDX_W-1:0]         coef_index;
        logic signed [DATA_W-1:0] coef_value;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
    } in_t;

    typedef struct packed {
        logic                     visible;
        logic signed [DATA_W-1:0] screen_x;
        logic signed [DATA_W-1:0] screen_y;
    } out_t;

    typedef struct packed {
        logic [DIM_W-1:0]  screen_width;
        logic [DIM_W-1:0]  screen_height;
        logic [WMIN_W-1:0] w_minimum;
    } cfg_t;

    typedef struct packed {
        logic signed [CLIP_W-1:0] x;
        logic signed [CLIP_W-1:0] y;
        logic signed [CLIP_W-1:0] w;
    } clip_t;

    typedef struct packed {
        logic             visible;
        logic             neg_x;
        logic             neg_y;
        logic [MID_W-1:0] mid_w;
        logic [MID_W-1:0] mid_h;
    } tag_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32'sh7fffffff);
        lo = -SUM_W'(33'sh080000000);
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[DATA_W-1:0];
    endfunction
endpackage
`default_nettype wire

// File: sv/wtsp_regs.sv
// configuration register file behind the apb port
`default_nettype none
module wtsp_regs import wtsp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output cfg_t                   cfg
);
    cfg_t cfg_reg;
    logic wr;

    assign wr  = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width  <= WIDTH_RESET;
            cfg_reg.screen_height <= HEIGHT_RESET;
            cfg_reg.w_minimum     <= WMIN_RESET;
        end else if (wr) begin
            unique case (paddr[3:2])
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= pwdata[DIM_W-1:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= pwdata[DIM_W-1:0];
                REG_W_MINIMUM:     cfg_reg.w_minimum     <= pwdata[WMIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SCREEN_WIDTH:  prdata = 32'(cfg_reg.screen_width);
            REG_SCREEN_HEIGHT: prdata = 32'(cfg_reg.screen_height);
            REG_W_MINIMUM:     prdata = 32'(cfg_reg.w_minimum);
            default:           prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

// File: sv/wtsp_clip.sv
// coefficient store and two-stage clip-space dot products
`default_nettype none
module wtsp_clip import wtsp_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  wire logic in_accept,
    input  wire in_t  in_data,
    output logic      out_valid,
    output clip_t     out_clip
);
    logic signed [DATA_W-1:0] coef_reg [NUM_COEFS];
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [CLIP_W-1:0] row3_reg [3];
    logic                     p1_valid_reg;
    logic                     p2_valid_reg;
    clip_t                    clip_reg;
    logic signed [DATA_W-1:0] pos [3];
    logic signed [CLIP_W-1:0] sum [3];
    logic signed [TERM_W-1:0] term [3][3];

    assign pos[0] = in_data.pos_x;
    assign pos[1] = in_data.pos_y;
    assign pos[2] = in_data.pos_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEFS; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (in_accept && in_data.command == CMD_LOAD
                     && in_data.coef_index < IDX_W'(NUM_COEFS)) begin
            coef_reg[in_data.coef_index] <= in_data.coef_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= in_accept && in_data.command == CMD_TRANSFORM;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    prod_reg[c][r] <= PROD_W'(coef_reg[c*4+r]) * PROD_W'(pos[r]);
                end
                row3_reg[c] <= CLIP_W'(coef_reg[c*4+3] >>> COEF_SHIFT);
            end
            clip_reg.x <= sum[0];
            clip_reg.y <= sum[1];
            clip_reg.w <= sum[2];
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                term[c][r] = prod_reg[c][r][PROD_W-1:COEF_FRAC_BITS];
            end
            sum[c] = row3_reg[c] + CLIP_W'(term[c][0]) + CLIP_W'(term[c][1])
                     + CLIP_W'(term[c][2]);
        end
    end

    assign out_valid = p2_valid_reg;
    assign out_clip  = clip_reg;
endmodule
`default_nettype wire

// File: sv/wtsp_div.sv
// two-lane restoring divider, one quotient bit per stage, shared divisor
`default_nettype none
module wtsp_div import wtsp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  num_x,
    input  wire logic [NUM_W-1:0]  num_y,
    input  wire logic [CLIP_W-1:0] den,
    input  wire tag_t              in_tag,
    output logic                   out_valid,
    output logic [MAG_W-1:0]       mag_x,
    output logic [MAG_W-1:0]       mag_y,
    output tag_t                   out_tag
);
    logic              vld_reg   [Q_W+1];
    tag_t              tag_reg   [Q_W+1];
    logic [CLIP_W-1:0] den_reg   [Q_W+1];
    logic [CLIP_W-1:0] rem_reg   [2][Q_W+1];
    logic [Q_W-1:0]    low_reg   [2][Q_W+1];
    logic [Q_W-1:0]    quo_reg   [2][Q_W+1];
    logic              ovf_reg   [2][Q_W+1];
    logic [CLIP_W:0]   trial     [2][Q_W+1];
    logic              ge        [2][Q_W+1];
    logic [NUM_W-1:0]  num_in    [2];
    logic [CLIP_W-1:0] top_in    [2];

    assign num_in[0] = num_x;
    assign num_in[1] = num_y;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            top_in[l] = CLIP_W'(num_in[l][NUM_W-1:Q_W]);
            trial[l][0] = '0;
            ge[l][0]    = 1'b0;
            for (int k = 1; k <= Q_W; k++) begin
                trial[l][k] = {rem_reg[l][k-1], low_reg[l][k-1][Q_W-1]};
                ge[l][k]    = trial[l][k] >= {1'b0, den_reg[k-1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= Q_W; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= Q_W; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg[0] <= in_tag;
            den_reg[0] <= den;
            for (int l = 0; l < 2; l++) begin
                ovf_reg[l][0] <= top_in[l] >= den;
                rem_reg[l][0] <= top_in[l];
                low_reg[l][0] <= num_in[l][Q_W-1:0];
                quo_reg[l][0] <= '0;
            end
            for (int k = 1; k <= Q_W; k++) begin
                tag_reg[k] <= tag_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                for (int l = 0; l < 2; l++) begin
                    ovf_reg[l][k] <= ovf_reg[l][k-1];
                    low_reg[l][k] <= {low_reg[l][k-1][Q_W-2:0], 1'b0};
                    quo_reg[l][k] <= {quo_reg[l][k-1][Q_W-2:0], ge[l][k]};
                    rem_reg[l][k] <= ge[l][k]
                                     ? CLIP_W'(trial[l][k] - {1'b0, den_reg[k-1]})
                                     : trial[l][k][CLIP_W-1:0];
                end
            end
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign out_tag   = tag_reg[Q_W];
    assign mag_x = ovf_reg[0][Q_W] ? MAG_W'(1) << Q_W : MAG_W'(quo_reg[0][Q_W]);
    assign mag_y = ovf_reg[1][Q_W] ? MAG_W'(1) << Q_W : MAG_W'(quo_reg[1][Q_W]);
endmodule
`default_nettype wire

// File: sv/world_to_screen_projection.sv
// top level: perspective projection pipeline with apb configuration
`default_nettype none
// Accepts one transaction per clock unless stalled and delivers one result per
// transform through two stages of dot products, an abs stage, two stages of
// centre scaling multiplies and a 34-stage restoring divider that yields one
// quotient bit per stage; loads update the coefficients at acceptance and
// produce no result. A one-entry skid stage behind the output register lets
// input flow on while a result waits, and stalls the whole pipeline only once
// that entry is taken.
module world_to_screen_projection import wtsp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_t               s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_t                   m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    cfg_t  cfg;
    logic  en;
    logic  in_accept;
    logic  clip_valid;
    clip_t clip;

    logic              p3_valid_reg;
    tag_t              p3_tag_reg;
    logic [CLIP_W-1:0] p3_ax_reg;
    logic [CLIP_W-1:0] p3_ay_reg;
    logic [CLIP_W-1:0] p3_den_reg;
    logic              p4_valid_reg;
    tag_t              p4_tag_reg;
    logic [CLIP_W-1:0] p4_den_reg;
    logic [MID_W+LO_W-1:0] p4_xl_reg;
    logic [MID_W+LO_W-1:0] p4_yl_reg;
    logic [MID_W+HI_W-1:0] p4_xh_reg;
    logic [MID_W+HI_W-1:0] p4_yh_reg;
    logic              p5_valid_reg;
    tag_t              p5_tag_reg;
    logic [CLIP_W-1:0] p5_den_reg;
    logic [NUM_W-1:0]  p5_nx_reg;
    logic [NUM_W-1:0]  p5_ny_reg;

    tag_t              tag3;
    logic              vis;
    logic              div_valid;
    tag_t              div_tag;
    logic [MAG_W-1:0]  mag_x;
    logic [MAG_W-1:0]  mag_y;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    out_t              result;
    logic              leaving;

    logic out_valid_reg;
    out_t out_data_reg;
    logic skid_valid_reg;
    out_t skid_data_reg;

    assign pready    = 1'b1;
    assign en        = !skid_valid_reg;
    assign s_ready   = en;
    assign in_accept = s_valid && en;

    wtsp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    wtsp_clip u_clip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_accept (in_accept),
        .in_data   (s_data),
        .out_valid (clip_valid),
        .out_clip  (clip)
    );

    // visibility, signs and centres
    always_comb begin
        vis = clip.w > $signed({{(CLIP_W-WMIN_W){1'b0}}, cfg.w_minimum})
              - CLIP_W'(1) && clip.w > CLIP_W'(0);
        tag3.visible = vis;
        tag3.neg_x   = clip.x[CLIP_W-1];
        tag3.neg_y   = clip.y[CLIP_W-1];
        tag3.mid_w   = MID_W'(cfg.screen_width) << (COORD_FRAC_BITS - 1);
        tag3.mid_h   = MID_W'(cfg.screen_height) << (COORD_FRAC_BITS - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
        end else if (en) begin
            p3_valid_reg <= clip_valid;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p3_tag_reg <= tag3;
            p3_ax_reg  <= clip.x[CLIP_W-1] ? CLIP_W'(-clip.x) : CLIP_W'(clip.x);
            p3_ay_reg  <= clip.y[CLIP_W-1] ? CLIP_W'(-clip.y) : CLIP_W'(clip.y);
            p3_den_reg <= clip.w;

            p4_tag_reg <= p3_tag_reg;
            p4_den_reg <= p3_den_reg;
            p4_xl_reg  <= (MID_W+LO_W)'(p3_tag_reg.mid_w) * (MID_W+LO_W)'(p3_ax_reg[LO_W-1:0]);
            p4_yl_reg  <= (MID_W+LO_W)'(p3_tag_reg.mid_h) * (MID_W+LO_W)'(p3_ay_reg[LO_W-1:0]);
            p4_xh_reg  <= (MID_W+HI_W)'(p3_tag_reg.mid_w)
                          * (MID_W+HI_W)'(p3_ax_reg[CLIP_W-1:LO_W]);
            p4_yh_reg  <= (MID_W+HI_W)'(p3_tag_reg.mid_h)
                          * (MID_W+HI_W)'(p3_ay_reg[CLIP_W-1:LO_W]);

            p5_tag_reg <= p4_tag_reg;
            p5_den_reg <= p4_den_reg;
            p5_nx_reg  <= NUM_W'(p4_xl_reg) + (NUM_W'(p4_xh_reg) << LO_W);
            p5_ny_reg  <= NUM_W'(p4_yl_reg) + (NUM_W'(p4_yh_reg) << LO_W);
        end
    end

    wtsp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p5_valid_reg),
        .num_x     (p5_nx_reg),
        .num_y     (p5_ny_reg),
        .den       (p5_den_reg),
        .in_tag    (p5_tag_reg),
        .out_valid (div_valid),
        .mag_x     (mag_x),
        .mag_y     (mag_y),
        .out_tag   (div_tag)
    );

    // centre plus signed scaled offset, y flipped
    always_comb begin
        sum_x = $signed(SUM_W'(div_tag.mid_w))
                + (div_tag.neg_x ? -$signed(SUM_W'(mag_x)) : $signed(SUM_W'(mag_x)));
        sum_y = $signed(SUM_W'(div_tag.mid_h))
                + (div_tag.neg_y ? $signed(SUM_W'(mag_y)) : -$signed(SUM_W'(mag_y)));
        result.visible  = div_tag.visible;
        result.screen_x = div_tag.visible ? sat32(sum_x) : '0;
        result.screen_y = div_tag.visible ? sat32(sum_y) : '0;
    end

    assign leaving = div_valid && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg  <= skid_valid_reg || leaving;
            skid_valid_reg <= 1'b0;
        end else if (leaving) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end else if (leaving) begin
            skid_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output transaction");

    a_hidden_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.visible |-> m_data.screen_x == '0 && m_data.screen_y == '0)
        else $error("hidden point with non-zero coordinates");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_ready |=> skid_valid_reg && $stable(skid_data_reg))
        else $error("skid entry lost while output stalled");
`endif
endmodule
`default_nettype wire
